>>> rtl/core/bmrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_pkg
// Shared constants, record types and stack control for the bracket matching
// run folding compiler.
// ----------------------------------------------------------------------------
package bmrf_pkg;

   localparam int MAX_PROGRAM = 65536;
   localparam int MAX_NESTING = 256;
   localparam int MAX_RESULTS = 4;
   localparam int FOLD_MAX    = 65536;

   localparam int NP_W      = $clog2(MAX_PROGRAM + 1);
   localparam int FILL_W    = $clog2(MAX_NESTING + 1);
   localparam int ENTRY_W   = NP_W;
   localparam int POS_W     = 16;
   localparam int OPERAND_W = 17;
   localparam int AMOUNT_W  = 17;
   localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W     = $clog2(MAX_RESULTS);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_IN    = 8'h2C;

   typedef enum logic [1:0] {
      KIND_INSTR,
      KIND_PATCH,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_RIGHT,
      OP_LEFT,
      OP_LOOP_START,
      OP_LOOP_END,
      OP_INPUT,
      OP_OUTPUT
   } opcode_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_UNMATCHED_CLOSE,
      ERR_UNCLOSED_OPEN,
      ERR_TOO_DEEP,
      ERR_TOO_LONG
   } error_type;

   typedef struct packed {
      kind_type               kind;
      logic [POS_W-1:0]       position;
      opcode_type             opcode;
      logic [OPERAND_W-1:0]   operand;
      error_type              error_code;
   } rec_type;

   typedef struct packed {
      rec_type [MAX_RESULTS-1:0] recs;
      logic [CNT_W-1:0]          count;
   } bundle_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic [ENTRY_W-1:0] push_val;
   } stack_ctl_type;

endpackage
`default_nettype wire

>>> rtl/core/bracket_matching_run_folding_compiler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_matching_run_folding_compiler_top
// Streaming compiler: source bytes in, instruction/patch/done/error records
// out, with run folding and bracket matching on a shifting cell stack.
//
// Usage:
//  - req_ channel: one source byte per transfer, req_last_char on the final
//    byte of a program. After that byte all state is back to reset.
//  - rsp_ channel: one record per transfer; rsp_last_result marks the last
//    record caused by a byte. Bytes that only extend a run give no record.
//  - Decode: a byte is decoded in its transfer cycle; its records go to the
//    head bundle (skid if the head is busy) and are offered one per transfer.
//  - Throughput: one byte per cycle while rsp_ready is high and each byte
//    gives at most one record; a byte giving k records (k up to 4, a close
//    bracket with a flush gives up to 3, a last byte up to 4) is drained one
//    record per transfer. Sustained rate is set by the output-side serializer.
//  - Nesting state lives in a chain of MAX_NESTING cells; push shifts the
//    chain down and pop shifts it up, one step per cycle at most.
//  - Stall: while rsp_ready is low the head bundle holds; one more byte is
//    taken into the skid bundle, then req_ready drops.
//  - Reset (synchronous, active high) clears run, position, nesting count,
//    error flag and both queue slots. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bracket_matching_run_folding_compiler_top
   import bmrf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_source_char,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_record_kind,
   output logic [15:0]      rsp_position,
   output logic [2:0]       rsp_opcode,
   output logic [16:0]      rsp_operand,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last_result
);

   logic               accept;
   stack_ctl_type      stack_ctl;
   logic [ENTRY_W-1:0] top_value;
   logic               bundle_valid;
   bundle_type         bundle;
   rec_type            rsp_rec;

   // byte transfer
   assign accept = req_valid && req_ready;

   bmrf_frontend u_frontend (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .source_char  (req_source_char),
      .last_char    (req_last_char),
      .top_value    (top_value),
      .stack_ctl    (stack_ctl),
      .bundle_valid (bundle_valid),
      .bundle       (bundle)
   );

   // open-bracket positions, top in cell 0
   bmrf_stack u_stack (
      .clock     (clock),
      .ctl       (stack_ctl),
      .top_value (top_value)
   );

   // records drain one per transfer
   bmrf_outq u_outq (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (bundle_valid),
      .in_bundle       (bundle),
      .in_ready        (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rec         (rsp_rec),
      .rsp_last_result (rsp_last_result)
   );

   assign rsp_record_kind = rsp_rec.kind;
   assign rsp_position    = rsp_rec.position;
   assign rsp_opcode      = rsp_rec.opcode;
   assign rsp_operand     = rsp_rec.operand;
   assign rsp_error_code  = rsp_rec.error_code;

endmodule
`default_nettype wire

>>> rtl/core/bmrf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_cell
// One entry of the shifting open-bracket stack: takes the entry above on a
// push, the entry below on a pop, holds otherwise.
// ----------------------------------------------------------------------------
module bmrf_cell
   import bmrf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               push,
   input  wire logic               pop,
   input  wire logic [ENTRY_W-1:0] above_value,
   input  wire logic [ENTRY_W-1:0] below_value,
   output logic      [ENTRY_W-1:0] entry_value
);

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (push) begin
         entry_in = above_value;
      end else if (pop) begin
         entry_in = below_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;

endmodule
`default_nettype wire

>>> rtl/core/bmrf_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_stack
// Chain of stack cells; cell 0 is the top. Push shifts the chain down,
// pop shifts it up.
// ----------------------------------------------------------------------------
module bmrf_stack
   import bmrf_pkg::*;
(
   input  wire logic          clock,
   input  wire stack_ctl_type ctl,
   output logic [ENTRY_W-1:0] top_value
);

   logic [ENTRY_W-1:0] cell_value [MAX_NESTING];

   for (genvar i = 0; i < MAX_NESTING; i++) begin : g_cell
      logic [ENTRY_W-1:0] above;
      logic [ENTRY_W-1:0] below;

      if (i == 0) begin : g_top
         assign above = ctl.push_val;
      end else begin : g_mid
         assign above = cell_value[i-1];
      end

      if (i == MAX_NESTING - 1) begin : g_bottom
         assign below = cell_value[i];
      end else begin : g_inner
         assign below = cell_value[i+1];
      end

      bmrf_cell u_cell (
         .clock       (clock),
         .push        (ctl.push),
         .pop         (ctl.pop),
         .above_value (above),
         .below_value (below),
         .entry_value (cell_value[i])
      );
   end

   assign top_value = cell_value[0];

endmodule
`default_nettype wire

>>> rtl/core/bmrf_frontend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_frontend
// Decodes one source byte per transfer, folds runs, tracks positions and
// nesting, and builds the bundle of records that byte causes.
// ----------------------------------------------------------------------------
module bmrf_frontend
   import bmrf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         source_char,
   input  wire logic               last_char,
   input  wire logic [ENTRY_W-1:0] top_value,
   output stack_ctl_type           stack_ctl,
   output logic                    bundle_valid,
   output bundle_type              bundle
);

   logic [1:0]          pk_ff, pk_in;
   logic [AMOUNT_W-1:0] pa_ff, pa_in;
   logic                hp_ff, hp_in;
   logic [NP_W-1:0]     np_ff, np_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                failed_ff, failed_in;

   rec_type [MAX_RESULTS-1:0] recs;
   logic [CNT_W-1:0]    n;
   logic                ok;
   logic                foldable;
   logic                need_flush;
   logic                start_run;
   logic                np_full;
   logic [1:0]          kind;
   logic                amt;
   logic [AMOUNT_W:0]   fold_sum;

   function automatic rec_type make_rec(kind_type k, logic [NP_W-1:0] pos,
                                        opcode_type op,
                                        logic [OPERAND_W-1:0] operand,
                                        error_type e);
      rec_type r;
      r.kind       = k;
      r.position   = POS_W'(pos);
      r.opcode     = op;
      r.operand    = operand;
      r.error_code = e;
      return r;
   endfunction

   always_comb begin
      pk_in      = pk_ff;
      pa_in      = pa_ff;
      hp_in      = hp_ff;
      np_in      = np_ff;
      fill_in    = fill_ff;
      failed_in  = failed_ff;
      recs       = '0;
      n          = '0;
      ok         = 1'b1;
      need_flush = 1'b0;
      start_run  = 1'b0;
      np_full    = 1'b0;
      stack_ctl  = '0;
      foldable   = 1'b1;
      kind       = 2'(OP_ADD);
      amt        = 1'b0;

      unique case (source_char) inside
         CH_PLUS: begin
            kind = 2'(OP_ADD);
            amt  = 1'b1;
         end
         CH_MINUS: begin
            kind = 2'(OP_SUB);
            amt  = 1'b1;
         end
         CH_RIGHT: begin
            kind = 2'(OP_RIGHT);
            amt  = 1'b1;
         end
         CH_LEFT: begin
            kind = 2'(OP_LEFT);
            amt  = 1'b1;
         end
         CH_OPEN, CH_CLOSE, CH_OUT, CH_IN: begin
            foldable = 1'b0;
         end
         default: begin
            kind = 2'(OP_ADD);
            amt  = 1'b0;
         end
      endcase

      fold_sum = {1'b0, pa_ff} + (AMOUNT_W+1)'(amt);

      if (accept && !failed_ff) begin
         // merge into the held run, or flush it
         if (foldable) begin
            if (hp_ff && pk_ff == kind && fold_sum <= (AMOUNT_W+1)'(FOLD_MAX)) begin
               pa_in = fold_sum[AMOUNT_W-1:0];
            end else begin
               need_flush = hp_ff;
               start_run  = 1'b1;
            end
         end else begin
            need_flush = hp_ff;
         end

         if (need_flush) begin
            hp_in = 1'b0;
            if (np_in >= NP_W'(MAX_PROGRAM)) begin
               recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0, ERR_TOO_LONG);
               n  = n + CNT_W'(1);
               ok = 1'b0;
            end else begin
               recs[n[IDX_W-1:0]] = make_rec(KIND_INSTR, np_in,
                                             opcode_type'(3'(pk_ff)),
                                             OPERAND_W'(pa_ff), ERR_NONE);
               n     = n + CNT_W'(1);
               np_in = np_in + NP_W'(1);
            end
         end

         if (ok && start_run) begin
            hp_in = 1'b1;
            pk_in = kind;
            pa_in = AMOUNT_W'(amt);
         end

         np_full = (np_in >= NP_W'(MAX_PROGRAM));

         if (ok && !foldable) begin
            unique case (source_char) inside
               CH_OPEN: begin
                  if (fill_ff >= FILL_W'(MAX_NESTING)) begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                   ERR_TOO_DEEP);
                     n  = n + CNT_W'(1);
                     ok = 1'b0;
                  end else if (np_full) begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                   ERR_TOO_LONG);
                     n  = n + CNT_W'(1);
                     ok = 1'b0;
                  end else begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_INSTR, np_in, OP_LOOP_START, '0,
                                                   ERR_NONE);
                     n                  = n + CNT_W'(1);
                     stack_ctl.push     = 1'b1;
                     stack_ctl.push_val = np_in;
                     fill_in            = fill_ff + FILL_W'(1);
                     np_in              = np_in + NP_W'(1);
                  end
               end
               CH_CLOSE: begin
                  if (fill_ff == '0) begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                   ERR_UNMATCHED_CLOSE);
                     n  = n + CNT_W'(1);
                     ok = 1'b0;
                  end else if (np_full) begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                   ERR_TOO_LONG);
                     n  = n + CNT_W'(1);
                     ok = 1'b0;
                  end else begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_INSTR, np_in, OP_LOOP_END,
                                                   OPERAND_W'(top_value), ERR_NONE);
                     n = n + CNT_W'(1);
                     // patch record gives the loop start its partner
                     recs[n[IDX_W-1:0]] = make_rec(KIND_PATCH, NP_W'(top_value),
                                                   OP_LOOP_START, OPERAND_W'(np_in),
                                                   ERR_NONE);
                     n             = n + CNT_W'(1);
                     stack_ctl.pop = 1'b1;
                     fill_in       = fill_ff - FILL_W'(1);
                     np_in         = np_in + NP_W'(1);
                  end
               end
               default: begin
                  if (np_full) begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                   ERR_TOO_LONG);
                     n  = n + CNT_W'(1);
                     ok = 1'b0;
                  end else begin
                     recs[n[IDX_W-1:0]] = make_rec(KIND_INSTR, np_in,
                                                   (source_char == CH_OUT) ? OP_OUTPUT
                                                                           : OP_INPUT,
                                                   '0, ERR_NONE);
                     n     = n + CNT_W'(1);
                     np_in = np_in + NP_W'(1);
                  end
               end
            endcase
         end

         // end of program: flush the run, then done, unclosed-open or too-long error
         if (ok && last_char) begin
            if (hp_in) begin
               hp_in = 1'b0;
               if (np_in >= NP_W'(MAX_PROGRAM)) begin
                  recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                ERR_TOO_LONG);
                  n  = n + CNT_W'(1);
                  ok = 1'b0;
               end else begin
                  recs[n[IDX_W-1:0]] = make_rec(KIND_INSTR, np_in,
                                                opcode_type'(3'(pk_in)),
                                                OPERAND_W'(pa_in), ERR_NONE);
                  n     = n + CNT_W'(1);
                  np_in = np_in + NP_W'(1);
               end
            end
            if (ok) begin
               if (fill_in != '0) begin
                  recs[n[IDX_W-1:0]] = make_rec(KIND_ERROR, np_in, OP_ADD, '0,
                                                ERR_UNCLOSED_OPEN);
                  n  = n + CNT_W'(1);
                  ok = 1'b0;
               end else begin
                  recs[n[IDX_W-1:0]] = make_rec(KIND_DONE, np_in, OP_ADD,
                                                OPERAND_W'(np_in), ERR_NONE);
                  n = n + CNT_W'(1);
               end
            end
         end

         if (!ok) begin
            failed_in = 1'b1;
         end
      end

      if (accept && last_char) begin
         pk_in     = '0;
         pa_in     = '0;
         hp_in     = 1'b0;
         np_in     = '0;
         fill_in   = '0;
         failed_in = 1'b0;
      end

      bundle.recs  = recs;
      bundle.count = n;
      bundle_valid = (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_ff     <= '0;
         pa_ff     <= '0;
         hp_ff     <= 1'b0;
         np_ff     <= '0;
         fill_ff   <= '0;
         failed_ff <= 1'b0;
      end else begin
         pk_ff     <= pk_in;
         pa_ff     <= pa_in;
         hp_ff     <= hp_in;
         np_ff     <= np_in;
         fill_ff   <= fill_in;
         failed_ff <= failed_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/bmrf_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmrf_outq
// Two-bundle output queue: a head bundle drained one record per transfer,
// and a skid bundle that lets the next byte in while the head drains.
// ----------------------------------------------------------------------------
module bmrf_outq
   import bmrf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire bundle_type in_bundle,
   output logic            in_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rec_type         rsp_rec,
   output logic            rsp_last_result
);

   logic             head_valid_ff, head_valid_in;
   bundle_type       head_ff, head_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             skid_valid_ff, skid_valid_in;
   bundle_type       skid_ff, skid_in;
   logic             fire;
   logic             head_done;

   assign in_ready        = !skid_valid_ff;
   assign rsp_valid       = head_valid_ff;
   assign rsp_rec         = head_ff.recs[idx_ff];
   assign rsp_last_result = (idx_ff == IDX_W'(head_ff.count - CNT_W'(1)));
   assign fire            = head_valid_ff && rsp_ready;
   assign head_done       = fire && rsp_last_result;

   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;

      if (head_done || !head_valid_ff) begin
         idx_in = '0;
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            head_valid_in = 1'b1;
            head_in       = in_bundle;
         end else begin
            head_valid_in = 1'b0;
         end
      end else begin
         if (fire) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (in_valid) begin
            skid_valid_in = 1'b1;
            skid_in       = in_bundle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
         idx_ff        <= idx_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid bundle held with empty head");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff |-> (head_ff.count != '0))
      else $error("empty bundle in head");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff |-> (CNT_W'(idx_ff) < head_ff.count))
      else $error("record index past bundle count");

   a_last_frees_head: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && rsp_ready && rsp_last_result && !skid_valid_ff && !in_valid)
      |=> !head_valid_ff)
      else $error("head not freed after its last record");

endmodule
`default_nettype wire

>>> tb/sv/bracket_matching_run_folding_compiler_top_tb.sv
// ----------------------------------------------------------------------------
// bracket_matching_run_folding_compiler_top_tb
// Self-checking bench for the streaming source compiler. Source bytes go in
// through the req_ channel. A scoreboard model folds runs, matches brackets
// and flags errors, and builds a queue of expected records. The monitor
// checks every rsp_ transfer against the oldest queued record, field by field.
// ----------------------------------------------------------------------------
module bracket_matching_run_folding_compiler_top_tb
   import bmrf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 50_000;
   localparam int RANDOM_BYTES = 425;
   localparam int IDLE_PCT     = 29;
   localparam int PRINT_CAP    = 40;

   // one source byte waiting to be driven
   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         calm;   // no idling on either side while these flow
   } src_item_type;

   // one expected output record
   typedef struct {
      kind_type         kind;
      logic [15:0]      pos;
      opcode_type       op;
      logic [16:0]      arg;
      error_type        err;
      logic             tail;
   } compiled_rec_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_source_char = 8'h00;
   logic        req_last_char   = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [1:0]  rsp_record_kind;
   logic [15:0] rsp_position;
   logic [2:0]  rsp_opcode;
   logic [16:0] rsp_operand;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_result;

   bracket_matching_run_folding_compiler_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source_char (req_source_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_record_kind (rsp_record_kind),
      .rsp_position    (rsp_position),
      .rsp_opcode      (rsp_opcode),
      .rsp_operand     (rsp_operand),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_result (rsp_last_result)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Scoreboard state: the compiler as the bench sees it
   // ------------------------------------------------------------------------
   src_item_type     src_items[$];
   compiled_rec_type owed_records[$];
   compiled_rec_type step_out[$];     // records caused by the byte in hand

   opcode_type run_op;             // held fold run
   int         run_total;
   bit         run_live;
   int         instr_count;        // instructions emitted in this program
   int         open_pos [MAX_NESTING];
   int         open_depth;
   bit         halted;             // error seen, ignore rest of program

   int mismatch_count = 0;
   int bytes_taken    = 0;
   int programs_done  = 0;
   int records_seen   = 0;
   int patches_seen   = 0;
   int dones_seen     = 0;
   int errors_seen    = 0;
   int cycle_count    = 0;

   bit               byte_taken = 1'b0;   // set on a req_ transfer, cleared at negedge
   bit               quiet_out  = 1'b0;   // receiver follows the sender's calm flag
   src_item_type     head;
   compiled_rec_type want;

   task automatic flag_mismatch(string note);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] MISMATCH: %s", $realtime, note);
   endtask

   function automatic void put_rec(kind_type k, int p, opcode_type o, int a, error_type e);
      compiled_rec_type r;
      r.kind = k;
      r.pos  = p[15:0];
      r.op   = o;
      r.arg  = a[16:0];
      r.err  = e;
      r.tail = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic bit raise_fault(error_type e);
      put_rec(KIND_ERROR, instr_count, OP_ADD, 0, e);
      halted = 1'b1;
      return 1'b0;
   endfunction

   function automatic bit place_instr(opcode_type o, int a);
      if (instr_count >= MAX_PROGRAM)
         return raise_fault(ERR_TOO_LONG);
      put_rec(KIND_INSTR, instr_count, o, a, ERR_NONE);
      instr_count++;
      return 1'b1;
   endfunction

   function automatic bit flush_run();
      if (!run_live)
         return 1'b1;
      run_live = 1'b0;
      return place_instr(run_op, run_total);
   endfunction

   function automatic void clear_program();
      run_op      = OP_ADD;
      run_total   = 0;
      run_live    = 1'b0;
      instr_count = 0;
      open_depth  = 0;
      halted      = 1'b0;
   endfunction

   // returns 0 once the byte has raised an error
   function automatic bit compile_byte(logic [7:0] c);
      opcode_type k;
      int         amt;
      bit         fold;
      int         open_at;
      int         here;
      k    = OP_ADD;
      amt  = 0;
      fold = 1'b1;
      case (c) inside
         CH_PLUS:  amt = 1;
         CH_MINUS: begin
            k = OP_SUB;
            amt = 1;
         end
         CH_RIGHT: begin
            k = OP_RIGHT;
            amt = 1;
         end
         CH_LEFT: begin
            k = OP_LEFT;
            amt = 1;
         end
         CH_OPEN, CH_CLOSE, CH_OUT, CH_IN: fold = 1'b0;
         default: ;                // stray byte: add by zero
      endcase

      if (fold) begin
         if (run_live && run_op == k && run_total + amt <= FOLD_MAX) begin
            run_total += amt;
            return 1'b1;
         end
         // kind change or amount would overflow: emit and restart the run
         if (!flush_run())
            return 1'b0;
         run_live  = 1'b1;
         run_op    = k;
         run_total = amt;
         return 1'b1;
      end

      if (!flush_run())
         return 1'b0;

      case (c)
         CH_OPEN: begin
            if (open_depth >= MAX_NESTING)
               return raise_fault(ERR_TOO_DEEP);
            here = instr_count;
            if (!place_instr(OP_LOOP_START, 0))
               return 1'b0;
            open_pos[open_depth] = here;
            open_depth++;
            return 1'b1;
         end
         CH_CLOSE: begin
            if (open_depth == 0)
               return raise_fault(ERR_UNMATCHED_CLOSE);
            open_at = open_pos[open_depth-1];
            here    = instr_count;
            if (!place_instr(OP_LOOP_END, open_at))
               return 1'b0;
            open_depth--;
            // back-patch the loop start with its partner
            put_rec(KIND_PATCH, open_at, OP_LOOP_START, here, ERR_NONE);
            return 1'b1;
         end
         CH_OUT:  return place_instr(OP_OUTPUT, 0);
         default: return place_instr(OP_INPUT, 0);
      endcase
   endfunction

   // expected records for one transferred byte
   function automatic void predict_transfer(logic [7:0] c, logic last);
      step_out.delete();
      if (!halted) begin
         if (compile_byte(c) && last) begin
            if (flush_run()) begin
               if (open_depth != 0)
                  void'(raise_fault(ERR_UNCLOSED_OPEN));
               else
                  put_rec(KIND_DONE, instr_count, OP_ADD, instr_count, ERR_NONE);
            end
         end
      end
      if (step_out.size() != 0)
         step_out[step_out.size()-1].tail = 1'b1;
      foreach (step_out[i])
         owed_records.insert(owed_records.size(), step_out[i]);
      if (last)
         clear_program();
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_byte(logic [7:0] c, logic last, bit calm);
      src_item_type it;
      it.ch   = c;
      it.last = last;
      it.calm = calm;
      src_items.insert(src_items.size(), it);
   endtask

   task automatic push_run(logic [7:0] c, int n, bit calm);
      repeat (n) push_byte(c, 1'b0, calm);
   endtask

   function automatic logic [7:0] fold_byte(int i);
      case (i)
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_RIGHT;
         default: return CH_LEFT;
      endcase
   endfunction

   // random byte that is none of the eight commands
   function automatic logic [7:0] stray_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while (c == CH_PLUS || c == CH_MINUS || c == CH_RIGHT || c == CH_LEFT ||
                 c == CH_OPEN || c == CH_CLOSE || c == CH_OUT || c == CH_IN);
      return c;
   endfunction

   // Random program. Most are well formed with random content; the rest
   // carry an extra close, leave a loop open, or are raw noise.
   task automatic queue_random_program(bit calm);
      int         shape;
      int         len;
      int         depth;
      int         pick;
      logic [7:0] c;
      shape = $urandom_range(9);
      len   = $urandom_range(0, 20);
      depth = 0;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (shape == 9) begin
            c = 8'($urandom_range(255));
         end else if (pick < 35) begin
            c = fold_byte($urandom_range(3));
            push_run(c, $urandom_range(0, 3), calm);
         end else if (pick < 47) begin
            c = stray_byte();
         end else if (pick < 62) begin
            c = CH_OPEN;
            depth++;
         end else if (pick < 76 && (depth > 0 || shape == 7)) begin
            c = CH_CLOSE;
            if (depth > 0)
               depth--;
         end else if (pick < 88) begin
            c = CH_OUT;
         end else begin
            c = CH_IN;
         end
         push_byte(c, 1'b0, calm);
      end

      case (shape)
         7: begin
            // one close too many, then a byte that must be ignored
            push_run(CH_CLOSE, depth + 1, calm);
            push_byte(stray_byte(), 1'b1, calm);
         end
         8: begin
            push_byte(CH_OPEN, 1'b0, calm);
            push_byte(fold_byte($urandom_range(3)), 1'b1, calm);
         end
         9: push_byte(8'($urandom_range(255)), 1'b1, calm);
         default: begin
            if (depth > 0) begin
               // the closing bracket itself ends the program
               push_run(CH_CLOSE, depth - 1, calm);
               push_byte(CH_CLOSE, 1'b1, calm);
            end else begin
               pick = $urandom_range(5);
               if (pick < 4)
                  push_byte(fold_byte(pick), 1'b1, calm);
               else if (pick == 4)
                  push_byte(CH_OUT, 1'b1, calm);
               else
                  push_byte(stray_byte(), 1'b1, calm);
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the head byte at negedge, hold it until transferred
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         head = src_items.pop_front();
         predict_transfer(head.ch, head.last);
         quiet_out  = head.calm;
         byte_taken = 1'b1;
         bytes_taken++;
         if (head.last)
            programs_done++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_taken) begin
         if (src_items.size() != 0 &&
             (src_items[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid       <= 1'b1;
            req_source_char <= src_items[0].ch;
            req_last_char   <= src_items[0].last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      byte_taken = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Monitor: random backpressure at negedge, check every rsp_ transfer
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= quiet_out || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         records_seen++;
         case (rsp_record_kind)
            KIND_PATCH: patches_seen++;
            KIND_DONE:  dones_seen++;
            KIND_ERROR: errors_seen++;
            default: ;
         endcase
         if (owed_records.size() == 0) begin
            flag_mismatch($sformatf("record kind %0d pos %0d with nothing pending",
                                    rsp_record_kind, rsp_position));
         end else begin
            want = owed_records.pop_front();
            if (rsp_record_kind !== want.kind)
               flag_mismatch($sformatf("rec %0d kind got %0d want %0d",
                                       records_seen, rsp_record_kind, want.kind));
            if (rsp_position !== want.pos)
               flag_mismatch($sformatf("rec %0d position got %0d want %0d",
                                       records_seen, rsp_position, want.pos));
            if (rsp_opcode !== want.op)
               flag_mismatch($sformatf("rec %0d opcode got %0d want %0d",
                                       records_seen, rsp_opcode, want.op));
            if (rsp_operand !== want.arg)
               flag_mismatch($sformatf("rec %0d operand got %0d want %0d",
                                       records_seen, rsp_operand, want.arg));
            if (rsp_error_code !== want.err)
               flag_mismatch($sformatf("rec %0d error_code got %0d want %0d",
                                       records_seen, rsp_error_code, want.err));
            if (rsp_last_result !== want.tail)
               flag_mismatch($sformatf("rec %0d last_result got %0d want %0d",
                                       records_seen, rsp_last_result, want.tail));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d records still owed",
                  cycle_count, owed_records.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of test
   // ------------------------------------------------------------------------
   int bulk_mark;

   initial begin
      clear_program();

      // Directed: byte extremes, every opcode, close with pending run (four
      // records on the last byte).
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);          // stray bytes fold with '+'
      push_byte(CH_PLUS, 1'b0, 1'b0);
      push_byte(CH_PLUS, 1'b0, 1'b0);
      push_byte(CH_MINUS, 1'b0, 1'b0);
      push_byte(CH_RIGHT, 1'b0, 1'b0);
      push_byte(CH_RIGHT, 1'b0, 1'b0);
      push_byte(CH_LEFT, 1'b0, 1'b0);
      push_byte(CH_OPEN, 1'b0, 1'b0);
      push_byte(CH_IN, 1'b0, 1'b0);
      push_byte(CH_OUT, 1'b0, 1'b0);
      push_byte(CH_PLUS, 1'b0, 1'b0);
      push_byte(CH_CLOSE, 1'b1, 1'b0);
      // unmatched close on the last byte
      push_byte(CH_CLOSE, 1'b1, 1'b0);
      // open loops left at the end, after a flush
      push_byte(CH_OPEN, 1'b0, 1'b0);
      push_byte(CH_OPEN, 1'b0, 1'b0);
      push_byte(CH_MINUS, 1'b1, 1'b0);
      // error mid-program, then silence through the last byte
      push_byte(CH_CLOSE, 1'b0, 1'b0);
      push_byte(CH_PLUS, 1'b0, 1'b0);
      push_byte(CH_OUT, 1'b0, 1'b0);
      push_byte(CH_OPEN, 1'b0, 1'b0);
      push_byte(CH_CLOSE, 1'b1, 1'b0);
      // single-byte program
      push_byte(CH_PLUS, 1'b1, 1'b0);

      // Random programs; one stretch in the middle runs without idling.
      bulk_mark = src_items.size();
      while (src_items.size() < bulk_mark + RANDOM_BYTES)
         queue_random_program(src_items.size() >= bulk_mark + 150 &&
                              src_items.size() <  bulk_mark + 260);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: all bytes in, all records out, then a short settle
      while (src_items.size() != 0 || owed_records.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (owed_records.size() != 0)
         flag_mismatch($sformatf("%0d expected records never arrived",
                                 owed_records.size()));

      $display("Compiled %0d source bytes in %0d programs over %0d cycles",
               bytes_taken, programs_done, cycle_count);
      $display("Checked %0d records: %0d patches, %0d done, %0d errors, %0d mismatches",
               records_seen, patches_seen, dones_seen, errors_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
